/* hw/rtl/mre_pkg.sv */
// ----------------------------------------------------------------------------
// mre_pkg
// Types and constants shared by the ModRM/SIB/REX encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mre_pkg;

	localparam int NUM_SLOTS = 10;
	localparam int DEPTH     = 2;

	// slot positions of the byte run, in emission order
	localparam int SLOT_PFX  = 0;
	localparam int SLOT_REX  = 1;
	localparam int SLOT_ESC  = 2;
	localparam int SLOT_OPC  = 3;
	localparam int SLOT_MODR = 4;
	localparam int SLOT_SIB  = 5;
	localparam int SLOT_D0   = 6;
	localparam int SLOT_D1   = 7;
	localparam int SLOT_D2   = 8;
	localparam int SLOT_D3   = 9;

	localparam logic [7:0] BYTE_OSZ  = 8'h66;
	localparam logic [7:0] BYTE_ESC  = 8'h0F;
	localparam logic [7:0] REX_BASE  = 8'h40;
	localparam logic [7:0] MOD_REG   = 8'hC0;
	localparam logic [7:0] MOD_D8    = 8'h40;
	localparam logic [7:0] MOD_D32   = 8'h80;
	localparam logic [7:0] MOD_NONE  = 8'h00;
	localparam logic [7:0] SIB_ABS   = 8'h25;
	localparam logic [7:0] SIB_RSP   = 8'h24;

	localparam logic [1:0] MODE_16   = 2'd0;
	localparam logic [1:0] MODE_64   = 2'd2;

	localparam logic [1:0] OSZ_16    = 2'd1;
	localparam logic [1:0] OSZ_32    = 2'd2;
	localparam logic [1:0] OSZ_64    = 2'd3;

	localparam logic [4:0] BASE_RIP  = 5'd16;
	localparam logic [4:0] BASE_NONE = 5'd17;
	localparam logic [4:0] IDX_NONE  = 5'd16;

	localparam logic [2:0] RM_SIB    = 3'd4;
	localparam logic [2:0] RM_DISP   = 3'd5;

	localparam logic [1:0] RELOC_NONE = 2'd0;
	localparam logic [1:0] RELOC_ABS  = 2'd1;
	localparam logic [1:0] RELOC_REL  = 2'd2;

	typedef logic [NUM_SLOTS-1:0] slot_mask_t;

	// classified instruction, one queue entry
	typedef struct packed {
		slot_mask_t  mask;
		logic [7:0]  rex;
		logic [7:0]  opc;
		logic [7:0]  modrm;
		logic [7:0]  sib;
		logic [31:0] disp;
		logic [1:0]  dkind;
		logic        trunc;
		logic        status;
	} entry_t;

endpackage

`default_nettype wire

/* hw/rtl/mre_front.sv */
// ----------------------------------------------------------------------------
// mre_front
// Mode register and instruction classification into a byte-slot descriptor.
// ----------------------------------------------------------------------------
`default_nettype none

module mre_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            mode_we,
	input  wire logic [1:0]      mode_wdata,
	input  wire logic [3:0]      reg_num,
	input  wire logic [1:0]      operand_size,
	input  wire logic            rm_is_memory,
	input  wire logic [3:0]      rm_reg_num,
	input  wire logic [4:0]      base_reg,
	input  wire logic [4:0]      index_reg,
	input  wire logic [63:0]     displacement,
	input  wire logic            has_symbol,
	input  wire logic            force_rex,
	input  wire logic [7:0]      opcode_byte,
	input  wire logic            two_byte_opcode,
	output mre_pkg::entry_t      entry
);

	logic [1:0]  mode_q;
	logic        long_mode;
	logic        err;
	logic        b_bit;
	logic [7:0]  rex;
	logic [63:0] rip_disp;
	logic [63:0] tval;
	logic        fits32;
	logic        fits8;
	logic [2:0]  low;
	logic [7:0]  mod;
	logic [7:0]  regf;
	mre_pkg::slot_mask_t mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= mre_pkg::MODE_64;
		end else if (mode_we) begin
			mode_q <= mode_wdata;
		end
	end

	assign long_mode = mode_q[1];
	assign rip_disp  = displacement - 64'd4;
	assign tval      = (base_reg == mre_pkg::BASE_RIP) ? rip_disp : displacement;
	assign fits32    = (&tval[63:31]) | ~(|tval[63:31]);
	assign fits8     = (&displacement[63:7]) | ~(|displacement[63:7]);
	assign low       = base_reg[2:0];
	assign regf      = {2'b00, reg_num[2:0], 3'b000};

	always_comb begin
		if (!long_mode) begin
			err = rm_is_memory || (operand_size == mre_pkg::OSZ_64) || reg_num[3]
				|| (!rm_is_memory && rm_reg_num[3]) || force_rex;
		end else begin
			err = rm_is_memory && ((index_reg != mre_pkg::IDX_NONE)
				|| (base_reg > mre_pkg::BASE_NONE));
		end
	end

	always_comb begin
		b_bit = rm_is_memory ? (!base_reg[4] && base_reg[3]) : rm_reg_num[3];
		rex = mre_pkg::REX_BASE
			| {4'b0000, operand_size == mre_pkg::OSZ_64, reg_num[3], 1'b0, b_bit};
	end

	always_comb begin
		mask = '0;
		mod  = mre_pkg::MOD_NONE;
		entry = '0;
		if ((operand_size == mre_pkg::OSZ_16 && mode_q != mre_pkg::MODE_16)
			|| (operand_size == mre_pkg::OSZ_32 && mode_q == mre_pkg::MODE_16)) begin
			mask[mre_pkg::SLOT_PFX] = 1'b1;
		end
		mask[mre_pkg::SLOT_REX]  = long_mode && (rex != mre_pkg::REX_BASE || force_rex);
		mask[mre_pkg::SLOT_ESC]  = two_byte_opcode;
		mask[mre_pkg::SLOT_OPC]  = 1'b1;
		mask[mre_pkg::SLOT_MODR] = 1'b1;
		entry.rex  = rex;
		entry.opc  = opcode_byte;
		entry.disp = tval[31:0];
		if (!rm_is_memory) begin
			entry.modrm = mre_pkg::MOD_REG | regf | {5'b00000, rm_reg_num[2:0]};
		end else if (base_reg == mre_pkg::BASE_NONE) begin
			entry.modrm = regf | {5'b00000, mre_pkg::RM_SIB};
			entry.sib   = mre_pkg::SIB_ABS;
			mask[mre_pkg::SLOT_SIB] = 1'b1;
			mask[mre_pkg::SLOT_D3:mre_pkg::SLOT_D0] = 4'hF;
			entry.dkind = has_symbol ? mre_pkg::RELOC_ABS : mre_pkg::RELOC_NONE;
			entry.trunc = !fits32;
		end else if (base_reg == mre_pkg::BASE_RIP) begin
			entry.modrm = regf | {5'b00000, mre_pkg::RM_DISP};
			mask[mre_pkg::SLOT_D3:mre_pkg::SLOT_D0] = 4'hF;
			entry.dkind = has_symbol ? mre_pkg::RELOC_REL : mre_pkg::RELOC_NONE;
			entry.trunc = !fits32;
		end else begin
			if (has_symbol) begin
				mod = mre_pkg::MOD_D32;
			end else if (displacement == 64'd0 && low != mre_pkg::RM_DISP) begin
				mod = mre_pkg::MOD_NONE;
			end else if (fits8) begin
				mod = mre_pkg::MOD_D8;
			end else begin
				mod = mre_pkg::MOD_D32;
			end
			entry.modrm = mod | regf | {5'b00000, low};
			entry.sib   = mre_pkg::SIB_RSP;
			mask[mre_pkg::SLOT_SIB] = (low == mre_pkg::RM_SIB);
			if (mod == mre_pkg::MOD_D8) begin
				mask[mre_pkg::SLOT_D0] = 1'b1;
			end else if (mod == mre_pkg::MOD_D32) begin
				mask[mre_pkg::SLOT_D3:mre_pkg::SLOT_D0] = 4'hF;
				entry.dkind = has_symbol ? mre_pkg::RELOC_ABS : mre_pkg::RELOC_NONE;
				entry.trunc = !fits32;
			end
		end
		entry.mask = mask;
		if (err) begin
			// single zero byte carrying the error status
			entry = '0;
			entry.mask[mre_pkg::SLOT_OPC] = 1'b1;
			entry.status = 1'b1;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/mre_queue.sv */
// ----------------------------------------------------------------------------
// mre_queue
// Small FIFO of classified instructions between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module mre_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire mre_pkg::entry_t push_entry,
	input  wire logic            pop,
	output logic                 full,
	output logic                 nonempty,
	output mre_pkg::entry_t      head
);

	localparam int AW = $clog2(mre_pkg::DEPTH);

	mre_pkg::entry_t mem_q [mre_pkg::DEPTH];
	logic [AW-1:0]   wptr_q;
	logic [AW-1:0]   rptr_q;
	logic [AW:0]     cnt_q;

	assign full     = (cnt_q == (AW+1)'(mre_pkg::DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == AW'(mre_pkg::DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == AW'(mre_pkg::DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/mre_back.sv */
// ----------------------------------------------------------------------------
// mre_back
// Walks the slot mask of the head entry and emits one byte per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mre_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            nonempty,
	input  wire mre_pkg::entry_t head,
	output logic                 pop,
	output logic                 strobe,
	output logic [7:0]           out_byte,
	output logic [1:0]           reloc_kind,
	output logic                 truncated,
	output logic                 status,
	output logic                 last
);

	logic                first_q;
	mre_pkg::slot_mask_t rem_q;
	mre_pkg::slot_mask_t cur;
	mre_pkg::slot_mask_t sel;
	mre_pkg::slot_mask_t rest;
	logic [7:0]          byte_d;
	logic [1:0]          kind_d;
	logic                strobe_q;
	logic [7:0]          byte_q;
	logic [1:0]          kind_q;
	logic                trunc_q;
	logic                status_q;
	logic                last_q;

	assign cur  = first_q ? head.mask : rem_q;
	assign sel  = cur & (~cur + 1'b1);
	assign rest = cur & ~sel;
	assign pop  = nonempty && (rest == '0);

	always_comb begin
		byte_d = '0;
		kind_d = mre_pkg::RELOC_NONE;
		for (int i = 0; i < mre_pkg::NUM_SLOTS; i++) begin
			if (sel[i]) begin
				unique case (i)
					mre_pkg::SLOT_PFX:  byte_d = mre_pkg::BYTE_OSZ;
					mre_pkg::SLOT_REX:  byte_d = head.rex;
					mre_pkg::SLOT_ESC:  byte_d = mre_pkg::BYTE_ESC;
					mre_pkg::SLOT_OPC:  byte_d = head.opc;
					mre_pkg::SLOT_MODR: byte_d = head.modrm;
					mre_pkg::SLOT_SIB:  byte_d = head.sib;
					mre_pkg::SLOT_D0:   byte_d = head.disp[7:0];
					mre_pkg::SLOT_D1:   byte_d = head.disp[15:8];
					mre_pkg::SLOT_D2:   byte_d = head.disp[23:16];
					mre_pkg::SLOT_D3:   byte_d = head.disp[31:24];
					default:            byte_d = '0;
				endcase
				if (i >= mre_pkg::SLOT_D0) begin
					kind_d = head.dkind;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= 1'b1;
			rem_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= nonempty;
			if (nonempty) begin
				first_q <= pop;
				rem_q   <= rest;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (nonempty) begin
			byte_q   <= byte_d;
			kind_q   <= kind_d;
			trunc_q  <= head.trunc;
			status_q <= head.status;
			last_q   <= pop;
		end
	end

	assign strobe     = strobe_q;
	assign out_byte   = byte_q;
	assign reloc_kind = kind_q;
	assign truncated  = trunc_q;
	assign status     = status_q;
	assign last       = last_q;

endmodule

`default_nettype wire

/* hw/rtl/x86_modrm_rex_encoder_top.sv */
// ----------------------------------------------------------------------------
// x86_modrm_rex_encoder_top
// Register-to-r/m instruction encoder: prefix, REX, escape, opcode, ModRM, SIB, disp.
//
//  channel   handshake         payload
//  -------   ---------------   ------------------------------------------------
//  request   start / busy      reg_num .. two_byte_opcode
//  result    strobe            out_byte, reloc_kind, truncated, status, last
//  mode      mode_we           mode_wdata
//
// One encoded byte leaves per cycle while the queue holds a run; an instruction
// yields 1 to 10 bytes, and a queued run follows the one before it with no gap.
// An accepted request is written into the queue, waits behind any queued runs and
// leaves through the back end's output register. busy rises when the two-entry
// queue is full. Reset clears the queue and sets 64-bit mode. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module x86_modrm_rex_encoder_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        mode_we,
	input  wire logic [1:0]  mode_wdata,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [3:0]  reg_num,
	input  wire logic [1:0]  operand_size,
	input  wire logic        rm_is_memory,
	input  wire logic [3:0]  rm_reg_num,
	input  wire logic [4:0]  base_reg,
	input  wire logic [4:0]  index_reg,
	input  wire logic [63:0] displacement,
	input  wire logic        has_symbol,
	input  wire logic        force_rex,
	input  wire logic [7:0]  opcode_byte,
	input  wire logic        two_byte_opcode,
	output logic             strobe,
	output logic [7:0]       out_byte,
	output logic [1:0]       reloc_kind,
	output logic             truncated,
	output logic             status,
	output logic             last
);

	mre_pkg::entry_t entry;
	mre_pkg::entry_t head;
	logic            full;
	logic            nonempty;
	logic            pop;
	logic            push;

	assign push = start && !full;
	assign busy = full;

	mre_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.mode_we         (mode_we),
		.mode_wdata      (mode_wdata),
		.reg_num         (reg_num),
		.operand_size    (operand_size),
		.rm_is_memory    (rm_is_memory),
		.rm_reg_num      (rm_reg_num),
		.base_reg        (base_reg),
		.index_reg       (index_reg),
		.displacement    (displacement),
		.has_symbol      (has_symbol),
		.force_rex       (force_rex),
		.opcode_byte     (opcode_byte),
		.two_byte_opcode (two_byte_opcode),
		.entry           (entry)
	);

	mre_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (entry),
		.pop        (pop),
		.full       (full),
		.nonempty   (nonempty),
		.head       (head)
	);

	mre_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.nonempty   (nonempty),
		.head       (head),
		.pop        (pop),
		.strobe     (strobe),
		.out_byte   (out_byte),
		.reloc_kind (reloc_kind),
		.truncated  (truncated),
		.status     (status),
		.last       (last)
	);

endmodule

`default_nettype wire

/* hw/rtl/mre_checker.sv */
// ----------------------------------------------------------------------------
// mre_checker
// Port-level checks on the encoder's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module mre_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       strobe,
	input  wire logic [7:0] out_byte,
	input  wire logic [1:0] reloc_kind,
	input  wire logic       truncated,
	input  wire logic       status,
	input  wire logic       last
);

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status |-> last)
		else $error("error word not last");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status |-> out_byte == 8'h00 && reloc_kind == mre_pkg::RELOC_NONE
			&& !truncated)
		else $error("error word not zero");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> reloc_kind <= mre_pkg::RELOC_REL)
		else $error("illegal reloc kind");

	a_run_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe && !status)
		else $error("gap inside run");

	a_trunc_steady: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> truncated == $past(truncated))
		else $error("truncated flag changed inside run");

endmodule

bind x86_modrm_rex_encoder_top mre_checker u_mre_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.strobe     (strobe),
	.out_byte   (out_byte),
	.reloc_kind (reloc_kind),
	.truncated  (truncated),
	.status     (status),
	.last       (last)
);

`default_nettype wire

/* bench/x86_modrm_rex_encoder_top_tb.sv */
// ----------------------------------------------------------------------------
// x86_modrm_rex_encoder_top_tb
// Self-checking bench for the ModRM/SIB/REX encoder. Instructions are driven
// through start/busy and every encoded byte on the strobe port is compared
// with a run predicted in the bench. The run goes through all four mode
// settings, register and memory forms, relocations, truncated displacements
// and rejected forms, with the sender idling at varied rates.
// ----------------------------------------------------------------------------
module x86_modrm_rex_encoder_top_tb;

	localparam logic [1:0] MODE_32    = 2'd1;
	localparam logic [1:0] MODE_ALT64 = 2'd3;
	localparam logic [1:0] OSZ_8      = 2'd0;
	localparam logic [7:0] REX_W      = 8'h08;
	localparam logic [7:0] REX_R      = 8'h04;
	localparam logic [7:0] REX_B      = 8'h01;
	localparam int         STALL_LIMIT = 1000;

	typedef struct {
		logic [3:0]  regn;
		logic [1:0]  osz;
		logic        mem;
		logic [3:0]  rm;
		logic [4:0]  base;
		logic [4:0]  idx;
		logic [63:0] disp;
		logic        sym;
		logic        frex;
		logic [7:0]  opc;
		logic        esc;
	} insn_t;

	typedef struct {
		logic [7:0] value;
		logic [1:0] kind;
		logic       trunc;
		logic       fault;
		logic       last;
	} enc_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        mode_we = 1'b0;
	logic [1:0]  mode_wdata = '0;
	logic        start = 1'b0;
	logic        busy;
	logic [3:0]  reg_num = '0;
	logic [1:0]  operand_size = '0;
	logic        rm_is_memory = 1'b0;
	logic [3:0]  rm_reg_num = '0;
	logic [4:0]  base_reg = '0;
	logic [4:0]  index_reg = '0;
	logic [63:0] displacement = '0;
	logic        has_symbol = 1'b0;
	logic        force_rex = 1'b0;
	logic [7:0]  opcode_byte = '0;
	logic        two_byte_opcode = 1'b0;
	logic        strobe;
	logic [7:0]  out_byte;
	logic [1:0]  reloc_kind;
	logic        truncated;
	logic        status;
	logic        last;

	insn_t      insn_queue[$];
	enc_byte_t  expected_bytes[$];
	insn_t      cur_insn;
	enc_byte_t  want;
	logic [1:0] cur_mode = mre_pkg::MODE_64;
	int         idle_pct = 0;
	int         errors = 0;
	int         n_insn = 0;
	int         n_bytes = 0;
	int         n_faults = 0;
	int         n_reloc = 0;
	int         n_trunc = 0;
	int         quiet_cycles = 0;

	x86_modrm_rex_encoder_top i_dut (.*);

	always #6 clk = ~clk;

	function automatic enc_byte_t plain(logic [7:0] b, logic [1:0] kind);
		enc_byte_t e;
		e.value = b;
		e.kind = kind;
		e.trunc = 1'b0;
		e.fault = 1'b0;
		e.last = 1'b0;
		return e;
	endfunction

	function automatic logic fits_s8(logic [63:0] v);
		return v == {{56{v[7]}}, v[7:0]};
	endfunction

	function automatic logic fits_s32(logic [63:0] v);
		return v == {{32{v[31]}}, v[31:0]};
	endfunction

	// build the byte run of one instruction under the current mode
	task automatic encode_insn(input insn_t q);
		enc_byte_t   run[$];
		enc_byte_t   e;
		logic        long_mode;
		logic        bad;
		logic        trunc;
		logic        use_d32;
		logic [7:0]  rex;
		logic [7:0]  mod;
		logic [63:0] d;
		logic [1:0]  dkind;
		logic [2:0]  low;
		int          i;
		long_mode = (cur_mode == mre_pkg::MODE_64) || (cur_mode == MODE_ALT64);
		if (!long_mode)
			bad = q.mem || q.osz == mre_pkg::OSZ_64 || q.regn[3] || (!q.mem && q.rm[3])
				|| q.frex;
		else
			bad = q.mem && (q.idx != mre_pkg::IDX_NONE || q.base > mre_pkg::BASE_NONE);
		if (bad) begin
			e = plain(8'h00, mre_pkg::RELOC_NONE);
			e.fault = 1'b1;
			e.last = 1'b1;
			expected_bytes.push_back(e);
			n_faults++;
			return;
		end
		if ((q.osz == mre_pkg::OSZ_16 && cur_mode != mre_pkg::MODE_16)
				|| (q.osz == mre_pkg::OSZ_32 && cur_mode == mre_pkg::MODE_16))
			run.push_back(plain(mre_pkg::BYTE_OSZ, mre_pkg::RELOC_NONE));
		if (long_mode) begin
			rex = mre_pkg::REX_BASE;
			if (q.osz == mre_pkg::OSZ_64)
				rex |= REX_W;
			if (q.regn[3])
				rex |= REX_R;
			if (!q.mem && q.rm[3])
				rex |= REX_B;
			if (q.mem && q.base < mre_pkg::BASE_RIP && q.base[3])
				rex |= REX_B;
			if (rex != mre_pkg::REX_BASE || q.frex)
				run.push_back(plain(rex, mre_pkg::RELOC_NONE));
		end
		if (q.esc)
			run.push_back(plain(mre_pkg::BYTE_ESC, mre_pkg::RELOC_NONE));
		run.push_back(plain(q.opc, mre_pkg::RELOC_NONE));
		d = q.disp;
		dkind = mre_pkg::RELOC_NONE;
		use_d32 = 1'b0;
		if (!q.mem) begin
			run.push_back(plain(mre_pkg::MOD_REG | {2'b00, q.regn[2:0], q.rm[2:0]},
				mre_pkg::RELOC_NONE));
		end else if (q.base == mre_pkg::BASE_NONE) begin
			run.push_back(plain({2'b00, q.regn[2:0], mre_pkg::RM_SIB}, mre_pkg::RELOC_NONE));
			run.push_back(plain(mre_pkg::SIB_ABS, mre_pkg::RELOC_NONE));
			use_d32 = 1'b1;
			if (q.sym)
				dkind = mre_pkg::RELOC_ABS;
		end else if (q.base == mre_pkg::BASE_RIP) begin
			d = q.disp - 64'd4;
			run.push_back(plain({2'b00, q.regn[2:0], mre_pkg::RM_DISP}, mre_pkg::RELOC_NONE));
			use_d32 = 1'b1;
			if (q.sym)
				dkind = mre_pkg::RELOC_REL;
		end else begin
			low = q.base[2:0];
			if (q.sym)
				mod = mre_pkg::MOD_D32;
			else if (q.disp == '0 && low != mre_pkg::RM_DISP)
				mod = mre_pkg::MOD_NONE;
			else if (fits_s8(q.disp))
				mod = mre_pkg::MOD_D8;
			else
				mod = mre_pkg::MOD_D32;
			run.push_back(plain(mod | {2'b00, q.regn[2:0], low}, mre_pkg::RELOC_NONE));
			if (low == mre_pkg::RM_SIB)
				run.push_back(plain(mre_pkg::SIB_RSP, mre_pkg::RELOC_NONE));
			if (mod == mre_pkg::MOD_D8)
				run.push_back(plain(q.disp[7:0], mre_pkg::RELOC_NONE));
			use_d32 = (mod == mre_pkg::MOD_D32);
			if (q.sym)
				dkind = mre_pkg::RELOC_ABS;
		end
		trunc = 1'b0;
		if (use_d32) begin
			trunc = !fits_s32(d);
			for (i = 0; i < 4; i++)
				run.push_back(plain(d[8*i +: 8], dkind));
			if (dkind != mre_pkg::RELOC_NONE)
				n_reloc += 4;
		end
		if (trunc)
			n_trunc++;
		foreach (run[k]) begin
			e = run[k];
			e.trunc = trunc;
			e.last = (k == run.size() - 1);
			expected_bytes.push_back(e);
		end
	endtask

	function automatic insn_t reg_insn(logic [3:0] r, logic [3:0] rm, logic [1:0] osz,
			logic frex, logic esc, logic [7:0] opc);
		insn_t q;
		q.regn = r;
		q.osz = osz;
		q.mem = 1'b0;
		q.rm = rm;
		q.base = mre_pkg::BASE_NONE;
		q.idx = mre_pkg::IDX_NONE;
		q.disp = '0;
		q.sym = 1'b0;
		q.frex = frex;
		q.opc = opc;
		q.esc = esc;
		return q;
	endfunction

	function automatic insn_t mem_insn(logic [3:0] r, logic [1:0] osz, logic [4:0] base,
			logic [4:0] idx, logic [63:0] disp, logic sym);
		insn_t q;
		q = reg_insn(r, 4'hF, osz, 1'b0, 1'b0, 8'h89);
		q.mem = 1'b1;
		q.base = base;
		q.idx = idx;
		q.disp = disp;
		q.sym = sym;
		return q;
	endfunction

	function automatic logic [63:0] random_disp();
		logic [63:0] v;
		logic [7:0]  b;
		logic [31:0] w;
		b = 8'($urandom);
		w = $urandom;
		case ($urandom_range(7))
			0: v = '0;
			1, 2: v = {{56{b[7]}}, b};
			3: v = {{32{w[31]}}, w};
			4: v = {$urandom, $urandom};
			5: v = 64'h0000_0000_7FFF_FFFC + 64'($urandom_range(8));
			6: v = 64'hFFFF_FFFF_7FFF_FFFC + 64'($urandom_range(8));
			default: v = w[0] ? 64'd124 + 64'($urandom_range(8))
					: 64'hFFFF_FFFF_FFFF_FF7B + 64'($urandom_range(8));
		endcase
		return v;
	endfunction

	function automatic insn_t random_insn(logic [1:0] m);
		insn_t q;
		int    pick;
		q.regn = 4'($urandom);
		q.osz = 2'($urandom);
		q.mem = 1'($urandom);
		q.rm = 4'($urandom);
		q.base = 5'($urandom);
		q.idx = 5'($urandom);
		q.disp = random_disp();
		q.sym = ($urandom_range(99) < 30);
		q.frex = ($urandom_range(99) < 20);
		q.opc = 8'($urandom);
		q.esc = 1'($urandom);
		pick = $urandom_range(99);
		if (m == mre_pkg::MODE_64 || m == MODE_ALT64) begin
			if (pick < 85) begin
				q.mem = (pick < 55);
				q.idx = mre_pkg::IDX_NONE;
				case ($urandom_range(5))
					0: q.base = mre_pkg::BASE_RIP;
					1: q.base = mre_pkg::BASE_NONE;
					default: q.base = 5'($urandom_range(15));
				endcase
			end else if (pick < 93) begin
				q.mem = 1'b1;
			end else begin
				q.mem = 1'b1;
				q.base = 5'($urandom_range(31, 18));
			end
		end else if (pick < 70) begin
			q.mem = 1'b0;
			q.regn[3] = 1'b0;
			q.rm[3] = 1'b0;
			q.osz = 2'($urandom_range(2));
			q.frex = 1'b0;
		end
		return q;
	endfunction

	function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] got);
		if (got !== exp_v) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got);
			errors++;
		end
	endfunction

	task automatic write_mode(input logic [1:0] m);
		@(posedge clk);
		mode_we <= 1'b1;
		mode_wdata <= m;
		@(posedge clk);
		mode_we <= 1'b0;
		cur_mode = m;
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (insn_queue.size() != 0 || start || expected_bytes.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				encode_insn(cur_insn);
				n_insn++;
			end
			if (!start || !busy) begin
				if (insn_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
					cur_insn = insn_queue.pop_front();
					reg_num <= cur_insn.regn;
					operand_size <= cur_insn.osz;
					rm_is_memory <= cur_insn.mem;
					rm_reg_num <= cur_insn.rm;
					base_reg <= cur_insn.base;
					index_reg <= cur_insn.idx;
					displacement <= cur_insn.disp;
					has_symbol <= cur_insn.sym;
					force_rex <= cur_insn.frex;
					opcode_byte <= cur_insn.opc;
					two_byte_opcode <= cur_insn.esc;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (expected_bytes.size() == 0) begin
				$display("%0t: byte %h arrived, expected none", $time, out_byte);
				errors++;
			end else begin
				want = expected_bytes.pop_front();
				check_field("out_byte", want.value, out_byte);
				check_field("reloc_kind", 8'(want.kind), 8'(reloc_kind));
				check_field("truncated", 8'(want.trunc), 8'(truncated));
				check_field("status", 8'(want.fault), 8'(status));
				check_field("last", 8'(want.last), 8'(last));
				n_bytes++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe || mode_we) begin
			quiet_cycles = 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("x86_modrm_rex_encoder_top verification failed");
			$finish;
		end else begin
			quiet_cycles++;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		idle_pct = 30;
		write_mode(mre_pkg::MODE_64);
		insn_queue.push_back(reg_insn(4'd0, 4'd0, OSZ_8, 1'b0, 1'b0, 8'h00));
		insn_queue.push_back(reg_insn(4'd15, 4'd15, mre_pkg::OSZ_64, 1'b1, 1'b1, 8'hFF));
		insn_queue.push_back(reg_insn(4'd8, 4'd0, mre_pkg::OSZ_16, 1'b0, 1'b0, 8'h89));
		insn_queue.push_back(reg_insn(4'd4, 4'd6, OSZ_8, 1'b1, 1'b0, 8'h88));
		insn_queue.push_back(mem_insn(4'd3, mre_pkg::OSZ_32, mre_pkg::BASE_NONE,
				mre_pkg::IDX_NONE, 64'h1234_5678, 1'b0));
		insn_queue.push_back(mem_insn(4'd7, mre_pkg::OSZ_64, mre_pkg::BASE_NONE,
				mre_pkg::IDX_NONE, '1, 1'b1));
		insn_queue.push_back(mem_insn(4'd0, mre_pkg::OSZ_32, mre_pkg::BASE_RIP,
				mre_pkg::IDX_NONE, '0, 1'b1));
		insn_queue.push_back(mem_insn(4'd1, mre_pkg::OSZ_32, mre_pkg::BASE_RIP,
				mre_pkg::IDX_NONE, 64'h8000_0003, 1'b0));
		insn_queue.push_back(mem_insn(4'd2, mre_pkg::OSZ_32, mre_pkg::BASE_RIP,
				mre_pkg::IDX_NONE, 64'hFFFF_FFFF_8000_0003, 1'b1));
		insn_queue.push_back(mem_insn(4'd0, mre_pkg::OSZ_32, 5'd0, mre_pkg::IDX_NONE,
				'0, 1'b0));
		insn_queue.push_back(mem_insn(4'd6, mre_pkg::OSZ_32, 5'd5, mre_pkg::IDX_NONE,
				'0, 1'b0));
		insn_queue.push_back(mem_insn(4'd9, mre_pkg::OSZ_64, 5'd13, mre_pkg::IDX_NONE,
				'0, 1'b0));
		insn_queue.push_back(mem_insn(4'd2, mre_pkg::OSZ_32, 5'd4, mre_pkg::IDX_NONE,
				64'd127, 1'b0));
		insn_queue.push_back(mem_insn(4'd5, mre_pkg::OSZ_16, 5'd12, mre_pkg::IDX_NONE,
				64'd128, 1'b0));
		insn_queue.push_back(mem_insn(4'd3, mre_pkg::OSZ_32, 5'd3, mre_pkg::IDX_NONE,
				64'hFFFF_FFFF_FFFF_FF80, 1'b0));
		insn_queue.push_back(mem_insn(4'd3, mre_pkg::OSZ_32, 5'd3, mre_pkg::IDX_NONE,
				64'hFFFF_FFFF_FFFF_FF7F, 1'b0));
		insn_queue.push_back(mem_insn(4'd1, mre_pkg::OSZ_32, 5'd7, mre_pkg::IDX_NONE,
				'0, 1'b1));
		insn_queue.push_back(mem_insn(4'd4, mre_pkg::OSZ_32, 5'd9, mre_pkg::IDX_NONE,
				64'h8000_0000_0000_0000, 1'b0));
		insn_queue.push_back(mem_insn(4'd7, mre_pkg::OSZ_32, 5'd2, mre_pkg::IDX_NONE,
				64'h7FFF_FFFF_FFFF_FFFF, 1'b1));
		insn_queue.push_back(mem_insn(4'd0, mre_pkg::OSZ_32, 5'd0, 5'd3, '0, 1'b0));
		insn_queue.push_back(mem_insn(4'd0, mre_pkg::OSZ_32, 5'd31, 5'd31, '0, 1'b0));
		wait_idle();

		write_mode(MODE_ALT64);
		repeat (80) insn_queue.push_back(random_insn(MODE_ALT64));
		wait_idle();

		idle_pct = 55;
		write_mode(mre_pkg::MODE_16);
		insn_queue.push_back(reg_insn(4'd1, 4'd2, mre_pkg::OSZ_32, 1'b0, 1'b0, 8'h01));
		insn_queue.push_back(reg_insn(4'd1, 4'd2, mre_pkg::OSZ_64, 1'b0, 1'b0, 8'h01));
		insn_queue.push_back(mem_insn(4'd0, mre_pkg::OSZ_16, 5'd3, mre_pkg::IDX_NONE,
				64'd8, 1'b0));
		insn_queue.push_back(reg_insn(4'd0, 4'd0, OSZ_8, 1'b1, 1'b0, 8'h88));
		repeat (60) insn_queue.push_back(random_insn(mre_pkg::MODE_16));
		wait_idle();

		write_mode(MODE_32);
		insn_queue.push_back(reg_insn(4'd7, 4'd7, mre_pkg::OSZ_16, 1'b0, 1'b1, 8'hAF));
		repeat (60) insn_queue.push_back(random_insn(MODE_32));
		wait_idle();

		idle_pct = 0;
		write_mode(mre_pkg::MODE_64);
		repeat (234) insn_queue.push_back(random_insn(mre_pkg::MODE_64));
		wait_idle();
		repeat (20) @(posedge clk);

		$display("Checked %0d bytes from %0d instructions across all four mode settings.",
				n_bytes, n_insn);
		$display("Covered %0d rejected forms, %0d relocation bytes, %0d truncated displacements.",
				n_faults, n_reloc, n_trunc);
		if (errors == 0)
			$display("x86_modrm_rex_encoder_top verification clean");
		else
			$display("x86_modrm_rex_encoder_top verification failed");
		$finish;
	end

endmodule

/* x86_modrm_rex_encoder_top.f */
hw/rtl/mre_pkg.sv
hw/rtl/mre_front.sv
hw/rtl/mre_queue.sv
hw/rtl/mre_back.sv
hw/rtl/x86_modrm_rex_encoder_top.sv
hw/rtl/mre_checker.sv
bench/x86_modrm_rex_encoder_top_tb.sv
